[hdl/mcd_pkg.sv]
// Shared types, constants and tables for the minute-count to calendar-date unit.
// Used by mcd_sub_unit and minutes_to_calendar_date_unit; depends on nothing.
package mcd_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned SubW   = CountW;  // operand width of the shared subtractor
  localparam int unsigned YearW  = 14;

  // Every span is counted in minutes so the walk runs on the input count itself.
  localparam logic [SubW-1:0] MinutesPerHour      = SubW'(60);
  localparam logic [SubW-1:0] MinutesPerDay       = SubW'(1440);
  localparam logic [SubW-1:0] MinutesPer400y      = SubW'(210379680);
  localparam logic [SubW-1:0] MinutesPerCentLong  = SubW'(52596000);
  localparam logic [SubW-1:0] MinutesPerCentShort = SubW'(52594560);
  localparam logic [SubW-1:0] MinutesPerQuadLong  = SubW'(2103840);
  localparam logic [SubW-1:0] MinutesPerQuadShort = SubW'(2102400);
  localparam logic [SubW-1:0] MinutesPerYearLong  = SubW'(527040);
  localparam logic [SubW-1:0] MinutesPerYearShort = SubW'(525600);
  localparam logic [SubW-1:0] MinutesPerMonth31   = SubW'(44640);
  localparam logic [SubW-1:0] MinutesPerMonth30   = SubW'(43200);
  localparam logic [SubW-1:0] MinutesPerMonth29   = SubW'(41760);
  localparam logic [SubW-1:0] MinutesPerMonth28   = SubW'(40320);

  localparam logic [YearW-1:0] BaseYear = YearW'(1900);
  localparam logic [YearW-1:0] YearsPerEra = YearW'(400);
  localparam logic [YearW-1:0] YearsPerCent = YearW'(100);
  localparam logic [YearW-1:0] YearsPerQuad = YearW'(4);

  // Century index (from 1900) whose first year is divisible by 400.
  localparam logic [1:0] LeapCentIdx = 2'd1;
  localparam logic [3:0] MonthFeb = 4'd1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ERA   = 9'b000000010,
    ST_CENT  = 9'b000000100,
    ST_QUAD  = 9'b000001000,
    ST_YEAR  = 9'b000010000,
    ST_MONTH = 9'b000100000,
    ST_DAY   = 9'b001000000,
    ST_HOUR  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic            ge;    // minuend >= subtrahend
    logic [SubW-1:0] diff;  // minuend - subtrahend, valid when ge
  } sub_res_t;

  function automatic logic [SubW-1:0] month_minutes(input logic [3:0] month,
                                                    input logic leap);
    logic [SubW-1:0] len;
    case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = MinutesPerMonth31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = MinutesPerMonth30;
      MonthFeb:                                  len = leap ? MinutesPerMonth29
                                                            : MinutesPerMonth28;
      default:                                   len = MinutesPerMonth31;
    endcase
    return len;
  endfunction

endpackage

[hdl/minutes_to_calendar_date_unit.sv]
// Minute count since 1900-01-01 00:00 UTC to Gregorian date and time of day.
// Depends on mcd_pkg and mcd_sub_unit.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries minute_count_i;
// the output channel (out_valid_o / out_stall_i) carries one date per input.
// A transfer happens at a rising edge where valid is high and stall is low.
// One item is worked on at a time: in_stall_o is high from the input transfer
// until the result has been taken. All work runs on the minute count through
// one 32-bit compare-and-subtract unit under a sequencer, one step per cycle:
//   0..20 whole 400-year spans, 0..3 centuries, 0..24 four-year spans,
//   0..3 single years, 0..11 months, 0..30 days, 0..23 hours,
// plus one final step for each of these seven phases as it ends.
// The result stays registered while out_stall_i is high; the next input is
// taken in the cycle after the output transfer. Reset (rst_ni low,
// asynchronous) returns the sequencer to idle and drops out_valid_o.
module minutes_to_calendar_date_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] minute_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [13:0] year_number_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o
);

  mcd_pkg::state_e state_q, state_d;

  logic [mcd_pkg::CountW-1:0] acc_q, acc_d;    // minutes not yet taken into a field
  logic [mcd_pkg::YearW-1:0]  year_q, year_d;
  logic [1:0]                 cent_q, cent_d;
  logic [4:0]                 quad_q, quad_d;
  logic [1:0]                 yr_q, yr_d;
  logic [3:0]                 month_q, month_d;
  logic [4:0]                 day_q, day_d;
  logic [4:0]                 hour_q, hour_d;

  logic [mcd_pkg::SubW-1:0] sub_a, sub_b;
  mcd_pkg::sub_res_t        sub_res;
  logic                     leap;

  // A year is leap when it opens a four-year span, unless it opens a
  // century that is not divisible by 400.
  assign leap = (yr_q == 2'd0) && ((quad_q != 5'd0) || (cent_q == mcd_pkg::LeapCentIdx));

  assign sub_a = acc_q;

  always_comb begin
    sub_b = mcd_pkg::MinutesPer400y;
    case (state_q)
      mcd_pkg::ST_CENT: begin
        sub_b = (cent_q == mcd_pkg::LeapCentIdx) ? mcd_pkg::MinutesPerCentLong
                                                 : mcd_pkg::MinutesPerCentShort;
      end
      mcd_pkg::ST_QUAD: begin
        sub_b = ((quad_q == 5'd0) && (cent_q != mcd_pkg::LeapCentIdx))
                ? mcd_pkg::MinutesPerQuadShort : mcd_pkg::MinutesPerQuadLong;
      end
      mcd_pkg::ST_YEAR: begin
        sub_b = leap ? mcd_pkg::MinutesPerYearLong : mcd_pkg::MinutesPerYearShort;
      end
      mcd_pkg::ST_MONTH: begin
        sub_b = mcd_pkg::month_minutes(month_q, leap);
      end
      mcd_pkg::ST_DAY: begin
        sub_b = mcd_pkg::MinutesPerDay;
      end
      mcd_pkg::ST_HOUR: begin
        sub_b = mcd_pkg::MinutesPerHour;
      end
      default: begin
        sub_b = mcd_pkg::MinutesPer400y;
      end
    endcase
  end

  mcd_sub_unit u_sub (
    .minuend_i    (sub_a),
    .subtrahend_i (sub_b),
    .res_o        (sub_res)
  );

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    year_d  = year_q;
    cent_d  = cent_q;
    quad_d  = quad_q;
    yr_d    = yr_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    case (state_q)
      mcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          acc_d   = minute_count_i;
          year_d  = mcd_pkg::BaseYear;
          cent_d  = '0;
          quad_d  = '0;
          yr_d    = '0;
          month_d = '0;
          day_d   = '0;
          hour_d  = '0;
          state_d = mcd_pkg::ST_ERA;
        end
      end
      mcd_pkg::ST_ERA: begin
        if (sub_res.ge) begin
          acc_d  = sub_res.diff;
          year_d = year_q + mcd_pkg::YearsPerEra;
        end else begin
          state_d = mcd_pkg::ST_CENT;
        end
      end
      mcd_pkg::ST_CENT: begin
        if (sub_res.ge) begin
          acc_d  = sub_res.diff;
          year_d = year_q + mcd_pkg::YearsPerCent;
          cent_d = cent_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_QUAD;
        end
      end
      mcd_pkg::ST_QUAD: begin
        if (sub_res.ge) begin
          acc_d  = sub_res.diff;
          year_d = year_q + mcd_pkg::YearsPerQuad;
          quad_d = quad_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_YEAR;
        end
      end
      mcd_pkg::ST_YEAR: begin
        if (sub_res.ge) begin
          acc_d  = sub_res.diff;
          year_d = year_q + 1'b1;
          yr_d   = yr_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_MONTH;
        end
      end
      mcd_pkg::ST_MONTH: begin
        if (sub_res.ge) begin
          acc_d   = sub_res.diff;
          month_d = month_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_DAY;
        end
      end
      mcd_pkg::ST_DAY: begin
        if (sub_res.ge) begin
          acc_d = sub_res.diff;
          day_d = day_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_HOUR;
        end
      end
      mcd_pkg::ST_HOUR: begin
        if (sub_res.ge) begin
          acc_d  = sub_res.diff;
          hour_d = hour_q + 1'b1;
        end else begin
          state_d = mcd_pkg::ST_DONE;
        end
      end
      mcd_pkg::ST_DONE: begin
        if (!out_stall_i) begin
          state_d = mcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    year_q  <= year_d;
    cent_q  <= cent_d;
    quad_q  <= quad_d;
    yr_q    <= yr_d;
    month_q <= month_d;
    day_q   <= day_d;
    hour_q  <= hour_d;
  end

  // After the hour walk only the minute of the hour is left in the accumulator.
  assign in_stall_o       = (state_q != mcd_pkg::ST_IDLE);
  assign out_valid_o      = (state_q == mcd_pkg::ST_DONE);
  assign day_of_month_o   = day_q + 5'd1;
  assign month_number_o   = month_q;
  assign year_number_o    = year_q;
  assign hour_of_day_o    = hour_q;
  assign minute_of_hour_o = acc_q[5:0];

endmodule

[hdl/mcd_sub_unit.sv]
// Shared compare-and-subtract unit of the calendar-date sequencer.
// Depends on mcd_pkg for the operand width and the result struct.
module mcd_sub_unit (
  input  logic [mcd_pkg::SubW-1:0] minuend_i,
  input  logic [mcd_pkg::SubW-1:0] subtrahend_i,
  output mcd_pkg::sub_res_t        res_o
);

  logic [mcd_pkg::SubW:0] diff_full;

  assign diff_full  = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign res_o.ge   = ~diff_full[mcd_pkg::SubW];
  assign res_o.diff = diff_full[mcd_pkg::SubW-1:0];

endmodule
